>>> sv/mdpt_pkg.sv
// shared constants and control structs for the mesh duplicate packet table
// no dependencies; used by every other file in sv/ except mdpt_ram
`default_nettype none

package mdpt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ID_W        = 16;
   localparam int KEY_W       = 3 * ID_W;
   localparam int FILL_W      = 5;

   // controller to datapath
   typedef struct packed {
      logic accept;     // word taken on the request channel
      logic scan;       // read one table entry this cycle
      logic load_out;   // move the finished result into the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_insert; // the word on the request channel is an insert
      logic empty;      // no valid entries
      logic last;       // entry being read is the last valid one
   } status_type;

endpackage

`default_nettype wire

>>> sv/mdpt_ifs.sv
// request and response channel interfaces for the duplicate packet table
// depends on mdpt_pkg for field widths
`default_nettype none

interface mdpt_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [mdpt_pkg::ID_W-1:0] network_id;
   logic [mdpt_pkg::ID_W-1:0] sender_id;
   logic [mdpt_pkg::ID_W-1:0] packet_id;

   modport source (output valid, output func, output network_id, output sender_id,
                   output packet_id, input ready);
   modport sink   (input valid, input func, input network_id, input sender_id,
                   input packet_id, output ready);
endinterface

interface mdpt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic                        flushed;
   logic [mdpt_pkg::FILL_W-1:0] fill_count;

   modport source (output valid, output hit, output flushed, output fill_count,
                   input ready);
   modport sink   (input valid, input hit, input flushed, input fill_count,
                   output ready);
endinterface

`default_nettype wire

>>> sv/mdpt_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module mdpt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/mdpt_ctrl.sv
// controller for the duplicate packet table: sequences lookup scan and result handoff
// depends on mdpt_pkg
`default_nettype none

module mdpt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      mdpt_pkg::cmd_type    cmd,
   input  wire mdpt_pkg::status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.accept   = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               if (status.req_insert || status.empty) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read data is compared here
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/mdpt_dp.sv
// datapath for the duplicate packet table: key register, fill count, scan index,
// compare and the response register; depends on mdpt_pkg and mdpt_ram
`default_nettype none

module mdpt_dp #(
   parameter int TABLE_DEPTH = mdpt_pkg::TABLE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_func,
   input  wire logic [mdpt_pkg::ID_W-1:0]     req_network_id,
   input  wire logic [mdpt_pkg::ID_W-1:0]     req_sender_id,
   input  wire logic [mdpt_pkg::ID_W-1:0]     req_packet_id,
   output      logic                          rsp_hit,
   output      logic                          rsp_flushed,
   output      logic [mdpt_pkg::FILL_W-1:0]   rsp_fill_count,
   input  wire mdpt_pkg::cmd_type             cmd,
   output      mdpt_pkg::status_type          status
);

   localparam int IDX_W = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   logic [mdpt_pkg::KEY_W-1:0]  key_ff, req_key, rd_data;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            idx_ff, idx_in, wr_addr;
   logic                        hit_ff, hit_in;
   logic                        flushed_ff, flushed_in;
   logic                        rd_pend_ff;
   logic                        full, wr_en;
   logic                        rsp_hit_ff, rsp_flushed_ff;
   logic [mdpt_pkg::FILL_W-1:0] rsp_fill_ff;

   assign req_key = {req_network_id, req_sender_id, req_packet_id};
   assign full    = (count_ff >= DEPTH_CNT);
   assign wr_en   = cmd.accept && req_func;
   // a full table is emptied, so the insert lands at entry 0
   assign wr_addr = full ? '0 : IDX_W'(count_ff);

   assign status.req_insert = req_func;
   assign status.empty      = (count_ff == '0);
   assign status.last       = ((CNT_W'(idx_ff) + ONE_CNT) == count_ff);

   mdpt_ram #(
      .WIDTH (mdpt_pkg::KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_key),
      .rd_en   (cmd.scan),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      flushed_in = flushed_ff;
      if (cmd.accept) begin
         idx_in     = '0;
         hit_in     = 1'b0;
         flushed_in = req_func && full;
         if (req_func) begin
            count_in = full ? ONE_CNT : count_ff + ONE_CNT;
         end
      end else begin
         if (cmd.scan) begin
            idx_in = idx_ff + IDX_W'(1);
         end
         if (rd_pend_ff && (rd_data == key_ff)) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         rd_pend_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      hit_ff     <= hit_in;
      flushed_ff <= flushed_in;
      if (cmd.accept) begin
         key_ff <= req_key;
      end
      if (cmd.load_out) begin
         rsp_hit_ff     <= hit_ff;
         rsp_flushed_ff <= flushed_ff;
         rsp_fill_ff    <= mdpt_pkg::FILL_W'(count_ff);
      end
   end

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_flushed    = rsp_flushed_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule

`default_nettype wire

>>> sv/mesh_duplicate_packet_table_top.sv
// top level of the mesh duplicate packet table
// depends on mdpt_pkg, mdpt_ifs, mdpt_ram, mdpt_ctrl and mdpt_dp
//
// usage
// - req_chan carries one word per packet: func (0 lookup, 1 insert) and the
//   identity triple network_id / sender_id / packet_id
// - rsp_chan returns exactly one word per request: hit, flushed and the
//   fill count after the request
// - a lookup reads the table ram one valid entry per cycle (those below the fill
//   count): n reads for n valid entries, then one state for the last compare,
//   then the hand-off once the response register is free; a lookup on an empty
//   table and an insert skip the scan and go straight to the hand-off
// - an insert writes the ram in the accept cycle; inserting into a full table
//   resets the count, writes entry 0 and flags flushed
// - one request in flight; the next is taken the cycle after the hand-off
// - the response register decouples the sides: a new request is accepted while
//   the previous response still waits, and a finished result holds in the
//   datapath until the receiver takes the old one
// - reset (synchronous, active high) empties the table by clearing the fill
//   count; the ram contents are not cleared and need no sweep
`default_nettype none

module mesh_duplicate_packet_table_top #(
   parameter int TABLE_DEPTH = mdpt_pkg::TABLE_DEPTH
) (
   input wire logic   clock,
   input wire logic   reset,
   mdpt_req_if.sink   req_chan,
   mdpt_rsp_if.source rsp_chan
);

   mdpt_pkg::cmd_type    cmd;
   mdpt_pkg::status_type status;

   // sequencing: request accept, scan walk, result handoff
   mdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // table ram, fill count, compare and response payload
   mdpt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_chan.func),
      .req_network_id (req_chan.network_id),
      .req_sender_id  (req_chan.sender_id),
      .req_packet_id  (req_chan.packet_id),
      .rsp_hit        (rsp_chan.hit),
      .rsp_flushed    (rsp_chan.flushed),
      .rsp_fill_count (rsp_chan.fill_count),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

`default_nettype wire

>>> dv/mesh_duplicate_packet_table_top_test.sv
`timescale 1ns / 1ps
// self-checking bench for the mesh duplicate packet table: directed then random lookups/inserts
// depends on mdpt_pkg, mdpt_ifs and the rtl under sv/
`default_nettype none

typedef enum bit {
   FUNC_LOOKUP = 1'b0,
   FUNC_INSERT = 1'b1
} dup_func_type;

typedef struct packed {
   logic                        hit;
   logic                        flushed;
   logic [mdpt_pkg::FILL_W-1:0] fill_count;
} dup_verdict_type;

// mirrors the seen-packet store and predicts the verdict of each accepted word
class dup_table_scoreboard;
   logic [mdpt_pkg::KEY_W-1:0] seen_keys[mdpt_pkg::TABLE_DEPTH];
   int unsigned                valid_count;
   dup_verdict_type            awaited_verdicts[$];
   int unsigned                errors;
   int unsigned                n_lookups, n_inserts, n_hits, n_flushes;

   function new();
      valid_count = 0;
      errors      = 0;
      n_lookups   = 0;
      n_inserts   = 0;
      n_hits      = 0;
      n_flushes   = 0;
      foreach (seen_keys[i]) seen_keys[i] = '0;
   endfunction

   function void note_packet(dup_func_type f, logic [15:0] net, logic [15:0] snd,
                             logic [15:0] pkt);
      logic [mdpt_pkg::KEY_W-1:0] key;
      dup_verdict_type            v;
      key = {net, snd, pkt};
      v   = '0;
      if (f == FUNC_LOOKUP) begin
         n_lookups++;
         for (int i = 0; i < valid_count && i < mdpt_pkg::TABLE_DEPTH; i++)
            if (seen_keys[i] == key) v.hit = 1'b1;
         if (v.hit) n_hits++;
      end else begin
         n_inserts++;
         // full table: empty it, then the new key lands at entry 0
         if (valid_count >= mdpt_pkg::TABLE_DEPTH) begin
            foreach (seen_keys[i]) seen_keys[i] = '0;
            valid_count = 0;
            v.flushed   = 1'b1;
            n_flushes++;
         end
         seen_keys[valid_count] = key;
         valid_count++;
      end
      v.fill_count = valid_count[mdpt_pkg::FILL_W-1:0];
      awaited_verdicts.push_back(v);
   endfunction

   function void check_verdict(logic hit, logic flushed,
                               logic [mdpt_pkg::FILL_W-1:0] fill_count);
      dup_verdict_type exp_v;
      if (awaited_verdicts.size() == 0) begin
         $error("response word with nothing outstanding: hit=%0b flushed=%0b fill_count=%0d",
                hit, flushed, fill_count);
         errors++;
         return;
      end
      exp_v = awaited_verdicts.pop_front();
      if (hit !== exp_v.hit) begin
         $error("hit: expected %0b, got %0b", exp_v.hit, hit);
         errors++;
      end
      if (flushed !== exp_v.flushed) begin
         $error("flushed: expected %0b, got %0b", exp_v.flushed, flushed);
         errors++;
      end
      if (fill_count !== exp_v.fill_count) begin
         $error("fill_count: expected %0d, got %0d", exp_v.fill_count, fill_count);
         errors++;
      end
   endfunction

   function void check_leftovers();
      if (awaited_verdicts.size() != 0) begin
         $error("%0d responses never arrived", awaited_verdicts.size());
         errors++;
      end
   endfunction
endclass

module mesh_duplicate_packet_table_top_test;

   localparam int ITEMS_PER_PHASE = 500;
   localparam int STALL_LIMIT     = 3000;  // cycles with no word moving on either side
   localparam int LONG_HOLD       = 400;   // receiver hold-off, well past a full pipeline
   localparam int DRAIN_CYCLES    = 40;    // extra wait after the final drain, before the leftover check

   logic clock;
   logic reset;

   mdpt_req_if req_chan ();
   mdpt_rsp_if rsp_chan ();

   mesh_duplicate_packet_table_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dup_table_scoreboard board;

   // idle percentages per phase, read by the driver and the receiver
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   // long receiver hold-off: main asks, receiver process counts it down
   bit          long_hold_req;
   int unsigned hold_left;
   int unsigned idle_run;

   // recently inserted keys, so lookups and repeat inserts can hit
   logic [47:0] recent_keys[16];
   int unsigned recent_n;
   int unsigned recent_wr;

   // clock: 20 ns period
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // receiver: ready changes on the falling edge only
   initial begin
      rsp_chan.ready = 1'b0;
      hold_left      = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // response check and watchdog, both sampled on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         idle_run <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_verdict(rsp_chan.hit, rsp_chan.flushed, rsp_chan.fill_count);
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready)) begin
            idle_run <= 0;
         end else if (idle_run >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            idle_run <= idle_run + 1;
         end
      end
   end

   // offer one word, idling first at random; returns on the falling edge after accept
   task automatic send_packet(dup_func_type f, logic [15:0] net, logic [15:0] snd,
                              logic [15:0] pkt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.func       = f;
      req_chan.network_id = net;
      req_chan.sender_id  = snd;
      req_chan.packet_id  = pkt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_packet(f, net, snd, pkt);
      if (f == FUNC_INSERT) begin
         recent_keys[recent_wr] = {net, snd, pkt};
         recent_wr = (recent_wr + 1) % 16;
         if (recent_n < 16) recent_n++;
      end
      @(negedge clock);
   endtask

   // sender stops until every outstanding response has been taken
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (board.awaited_verdicts.size() != 0) @(negedge clock);
   endtask

   // ids lean toward the extremes now and then
   function automatic logic [15:0] pick_id();
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // mostly realistic traffic: inserts of fresh packets and lookups of recent ones,
   // plus repeat inserts, near-miss lookups and pure noise
   task automatic send_random_packet();
      logic [47:0] key;
      int unsigned pick;
      pick = $urandom_range(99);
      if (recent_n != 0)
         key = recent_keys[$urandom_range(recent_n - 1)];
      else
         key = {pick_id(), pick_id(), pick_id()};
      if (pick < 40) begin
         // fresh insert
         key = {pick_id(), pick_id(), pick_id()};
         send_packet(FUNC_INSERT, key[47:32], key[31:16], key[15:0]);
      end else if (pick < 48) begin
         // duplicate insert of a recent packet
         send_packet(FUNC_INSERT, key[47:32], key[31:16], key[15:0]);
      end else if (pick < 78) begin
         // lookup of a recent packet, the usual duplicate check
         send_packet(FUNC_LOOKUP, key[47:32], key[31:16], key[15:0]);
      end else if (pick < 90) begin
         // near miss: one bit off a recent packet
         key[$urandom_range(47)] ^= 1'b1;
         send_packet(FUNC_LOOKUP, key[47:32], key[31:16], key[15:0]);
      end else begin
         send_packet(FUNC_LOOKUP, pick_id(), pick_id(), pick_id());
      end
   endtask

   initial begin
      board               = new();
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.func       = FUNC_LOOKUP;
      req_chan.network_id = '0;
      req_chan.sender_id  = '0;
      req_chan.packet_id  = '0;
      long_hold_req       = 1'b0;
      recent_n            = 0;
      recent_wr           = 0;
      send_idle_pct       = 30;
      recv_idle_pct       = 86;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, extremes, duplicates, fill to the top and flush
      send_packet(FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h0000);  // empty table never hits
      send_packet(FUNC_INSERT, 16'h0000, 16'h0000, 16'h0000);
      send_packet(FUNC_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_packet(FUNC_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // stored twice
      send_packet(FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h0000);
      send_packet(FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_packet(FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFE);  // one bit short
      for (int i = 0; i < 13; i++)
         send_packet(FUNC_INSERT, 16'(1 << i), 16'hA5A5 ^ 16'(i), 16'(i + 100));
      send_packet(FUNC_LOOKUP, 16'(1 << 12), 16'hA5A5 ^ 16'd12, 16'd112);  // last entry
      send_packet(FUNC_INSERT, 16'h5A5A, 16'h1234, 16'hFFFF);  // full table flushes
      send_packet(FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h0000);  // gone after flush
      send_packet(FUNC_LOOKUP, 16'h5A5A, 16'h1234, 16'hFFFF);
      wait_drained();

      // phase one: slow receiver
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_packet();
      wait_drained();

      // phase two: slow sender, with a full drain pause halfway
      send_idle_pct = 86;
      recv_idle_pct = 30;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
         if (i == ITEMS_PER_PHASE / 2) wait_drained();
         send_random_packet();
      end
      wait_drained();

      // phase three: no idling, one long receiver hold-off to back up the input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
         if (i == 100) long_hold_req = 1'b1;
         send_random_packet();
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      board.check_leftovers();
      $display("covered %0d lookups (%0d hits) and %0d inserts (%0d full-table flushes)",
               board.n_lookups, board.n_hits, board.n_inserts, board.n_flushes);
      $display("under sender/receiver idling, a long receiver hold-off and drain pauses");
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
sv/mdpt_pkg.sv
sv/mdpt_ifs.sv
sv/mdpt_ram.sv
sv/mdpt_ctrl.sv
sv/mdpt_dp.sv
sv/mesh_duplicate_packet_table_top.sv
dv/mesh_duplicate_packet_table_top_test.sv
